// File: rtl/stock_span_tracker_macros.svh
// assertion macros shared by the checker
`ifndef STOCK_SPAN_TRACKER_MACROS_SVH
`define STOCK_SPAN_TRACKER_MACROS_SVH

// same-cycle implication, off while in reset
`define SST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sst assertion failed");

// next-cycle implication, off while in reset
`define SST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sst assertion failed");

`endif

// File: rtl/sst_pkg.sv
package sst_pkg;

	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int PRICE_W           = 32;
	localparam int SPAN_W            = 11;
	localparam int S_TDATA_W         = 32;
	localparam int M_TDATA_W         = 16;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_AGE,
		OP_PUSH,
		OP_POP
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [PRICE_W-1:0] value;
	} cmd_t;

endpackage

// File: rtl/stock_span_tracker.sv
// stock span tracker
// slave stream: one signed 32-bit price per word on s_tdata
// master stream: one result word per price, span in bits 10:0, saturated in bit 11
// span counts the newest prices, this one included, that are at or below it,
// capped at the number of prices retained (HISTORY_DEPTH at most)
// the history is a stack of decreasing prices held in a row of HISTORY_DEPTH
// cells, newest on top; each cell keeps a price and its age and shifts to a
// neighbor on a push or a pop
// steps: take the word and age the stack, pop each entry at or below the
// price, then push the price and load the result once the register is free
// every price is pushed once and popped at most once, so pops never outnumber
// words over any long run; a new word is taken only after the last is pushed
// reset clears the cell valid bits and the fill count at once, no sweep
// a result waits in the output register while m_tready is low; the next word
// is taken meanwhile, and its push waits until the register is free
module stock_span_tracker
	import sst_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // price[31:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // span[10:0], saturated[11], zero[15:12]
);

	localparam int AW = $clog2(HISTORY_DEPTH + 1);

	cmd_t               cmd;
	logic               valid_c [HISTORY_DEPTH];
	logic [PRICE_W-1:0] value_c [HISTORY_DEPTH];
	logic [AW-1:0]      age_c   [HISTORY_DEPTH];

	sst_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.AW           (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.top_valid(valid_c[0]),
		.top_value(value_c[0]),
		.top_age  (age_c[0]),
		.cmd      (cmd)
	);

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		logic               up_valid, dn_valid;
		logic [PRICE_W-1:0] up_value, dn_value;
		logic [AW-1:0]      up_age, dn_age;

		if (i == 0) begin : g_head
			// new price enters the top with age zero
			assign up_valid = 1'b1;
			assign up_value = cmd.value;
			assign up_age   = '0;
		end else begin : g_mid
			assign up_valid = valid_c[i-1];
			assign up_value = value_c[i-1];
			assign up_age   = age_c[i-1];
		end

		if (i == HISTORY_DEPTH - 1) begin : g_tail
			assign dn_valid = 1'b0;
			assign dn_value = '0;
			assign dn_age   = '0;
		end else begin : g_body
			assign dn_valid = valid_c[i+1];
			assign dn_value = value_c[i+1];
			assign dn_age   = age_c[i+1];
		end

		sst_cell #(
			.HISTORY_DEPTH(HISTORY_DEPTH),
			.AW           (AW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (cmd.op),
			.up_valid(up_valid),
			.up_value(up_value),
			.up_age  (up_age),
			.dn_valid(dn_valid),
			.dn_value(dn_value),
			.dn_age  (dn_age),
			.valid   (valid_c[i]),
			.value   (value_c[i]),
			.age     (age_c[i])
		);
	end

endmodule

// File: rtl/sst_cell.sv
module sst_cell
	import sst_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int AW            = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  op_t                op,
	input  logic               up_valid,
	input  logic [PRICE_W-1:0] up_value,
	input  logic [AW-1:0]      up_age,
	input  logic               dn_valid,
	input  logic [PRICE_W-1:0] dn_value,
	input  logic [AW-1:0]      dn_age,
	output logic               valid,
	output logic [PRICE_W-1:0] value,
	output logic [AW-1:0]      age
);

	logic               valid_q;
	logic [PRICE_W-1:0] value_q;
	logic [AW-1:0]      age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_PUSH: valid_q <= up_valid;
				OP_POP:  valid_q <= dn_valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_AGE: begin
				// distance to the newest sample, capped at the depth
				if (age_q != AW'(HISTORY_DEPTH)) begin
					age_q <= age_q + AW'(1);
				end
			end
			OP_PUSH: begin
				value_q <= up_value;
				age_q   <= up_age;
			end
			OP_POP: begin
				value_q <= dn_value;
				age_q   <= dn_age;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

endmodule

// File: rtl/sst_ctrl.sv
module sst_ctrl
	import sst_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int AW            = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 top_valid,
	input  logic [PRICE_W-1:0]   top_value,
	input  logic [AW-1:0]        top_age,
	output cmd_t                 cmd
);

	localparam int EW = (AW > SPAN_W) ? AW : SPAN_W;

	state_t               state_q, state_d;
	logic [PRICE_W-1:0]   price_q;
	logic [AW-1:0]        fill_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                 accept;
	logic                 pop_hit;
	logic                 far;
	logic                 out_free;
	logic                 load_out;
	logic [EW-1:0]        span_wide;

	assign accept   = s_tvalid && s_tready;
	assign pop_hit  = top_valid && ($signed(top_value) <= $signed(price_q));
	// no greater entry inside the retained window
	assign far      = !top_valid || (top_age >= fill_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign span_wide = EW'(far ? fill_q : top_age);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!pop_hit && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		load_out  = 1'b0;
		cmd.op    = OP_HOLD;
		cmd.value = price_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_AGE;
				end
			end
			ST_SCAN: begin
				if (pop_hit) begin
					cmd.op = OP_POP;
				end else if (out_free) begin
					cmd.op   = OP_PUSH;
					load_out = 1'b1;
				end
			end
			default: begin
				cmd.op = OP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (fill_q != AW'(HISTORY_DEPTH))) begin
				fill_q <= fill_q + AW'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= s_tdata[PRICE_W-1:0];
		end
		if (load_out) begin
			m_tdata_q <= {{(M_TDATA_W - SPAN_W - 1){1'b0}}, far, span_wide[SPAN_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: rtl/sst_checker.sv
`include "stock_span_tracker_macros.svh"

module sst_checker
	import sst_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic s_word;
	logic m_stall;

	assign s_word  = s_tvalid && s_tready;
	assign m_stall = m_tvalid && !m_tready;

	// stalled result word stays put
	`SST_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata))
	// one price at a time: busy right after taking a word
	`SST_ASSERT_NEXT(a_busy_after_word, s_word, !s_tready)
	// a result never shows up the cycle right after a word is taken
	`SST_ASSERT_NEXT(a_no_early_result, s_word, !$rose(m_tvalid))
	// unused result bits stay zero
	`SST_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:SPAN_W+1] == '0)

endmodule

bind stock_span_tracker sst_checker u_sst_checker (.*);

// File: test/stock_span_tracker_test.sv
`timescale 1ns / 100ps

module stock_span_tracker_test;
	import sst_pkg::*;

	localparam int DEPTH        = HISTORY_DEPTH_DEF;
	localparam int TABLE_ROWS   = 22;
	localparam int RANDOM_ITEMS = 680;    // 702 to 761 words with the table
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic              saturated;
	} span_result_t;

	typedef struct {
		logic [PRICE_W-1:0] price;
		bit                 known;
		logic [SPAN_W-1:0]  span;
		logic               saturated;
	} price_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // price[31:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // span[10:0], saturated[11], zero[15:12]

	logic signed [PRICE_W-1:0] price_log [DEPTH];
	int                        log_fill;
	int                        log_slot;
	span_result_t              span_due [$];
	int                        fail_count;
	int                        words_sent;
	int                        words_seen;

	stock_span_tracker #(
		.HISTORY_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// span of the newest price over the retained history
	function automatic span_result_t span_of_price(input logic signed [PRICE_W-1:0] today);
		span_result_t r;
		int           slot;
		int           n;
		price_log[log_slot] = today;
		slot = log_slot;
		log_slot = (log_slot + 1) % DEPTH;
		if (log_fill < DEPTH) begin
			log_fill++;
		end
		r.span = '0;
		r.saturated = 1'b1;
		for (n = 0; n < log_fill; n++) begin
			if (price_log[slot] > today) begin
				r.saturated = 1'b0;
				break;
			end
			r.span = r.span + 1'b1;
			slot = (slot == 0) ? DEPTH - 1 : slot - 1;
		end
		return r;
	endfunction

	task automatic offer_price(input logic [PRICE_W-1:0] price, input bit known,
			input logic [SPAN_W-1:0] span, input logic saturated);
		span_result_t r;
		while (!(words_sent >= 400 && words_sent < 600) && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= price;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		r = span_of_price(price);
		if (known) begin
			r.span = span;
			r.saturated = saturated;
		end
		span_due = {span_due, r};
		words_sent++;
	endtask

	// result checking
	always @(posedge clk) begin
		span_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (span_due.size() == 0) begin
				report_mismatch("result word with nothing expected", m_tdata, 0);
			end else begin
				want = span_due.pop_front();
				if (m_tdata[SPAN_W-1:0] !== want.span)
					report_mismatch("span", m_tdata[SPAN_W-1:0], want.span);
				if (m_tdata[SPAN_W] !== want.saturated)
					report_mismatch("saturated", m_tdata[SPAN_W], want.saturated);
			end
		end
	end

	// receiver: random stalls, one long hold-off, one quiet stretch
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_seen >= 150) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (words_seen >= 450 && words_seen < 650) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		price_row_t                rows [TABLE_ROWS];
		logic signed [PRICE_W-1:0] level;
		logic [PRICE_W-1:0]        step;
		int                        kind;
		int                        run;
		int                        i;
		int                        random_sent;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		fail_count = 0;
		words_sent = 0;
		words_seen = 0;
		log_fill = 0;
		log_slot = 0;

		// first word after reset, extremes, equal prices
		rows = '{
			'{32'h0000_0000, 1'b1, 11'd1, 1'b1},
			'{32'h7fff_ffff, 1'b1, 11'd2, 1'b1},
			'{32'h8000_0000, 1'b1, 11'd1, 1'b0},
			'{32'h8000_0000, 1'b1, 11'd2, 1'b0},
			'{32'hffff_ffff, 1'b1, 11'd3, 1'b0},
			'{32'h7fff_ffff, 1'b1, 11'd6, 1'b1},
			'{32'h0000_0001, 1'b1, 11'd1, 1'b0},
			'{32'h0000_0001, 1'b1, 11'd2, 1'b0},
			'{32'h5555_5555, 1'b0, 11'd0, 1'b0},
			'{32'haaaa_aaaa, 1'b0, 11'd0, 1'b0},
			'{32'h7fff_fffe, 1'b0, 11'd0, 1'b0},
			'{32'h8000_0001, 1'b0, 11'd0, 1'b0},
			'{32'hffff_fffe, 1'b0, 11'd0, 1'b0},
			'{32'h0000_0002, 1'b0, 11'd0, 1'b0},
			'{32'h1234_5678, 1'b0, 11'd0, 1'b0},
			'{32'h1234_5678, 1'b0, 11'd0, 1'b0},
			'{32'hedcb_a987, 1'b0, 11'd0, 1'b0},
			'{32'h7fff_ffff, 1'b0, 11'd0, 1'b0},
			'{32'h4000_0000, 1'b0, 11'd0, 1'b0},
			'{32'h3fff_ffff, 1'b0, 11'd0, 1'b0},
			'{32'hc000_0000, 1'b0, 11'd0, 1'b0},
			'{32'h0000_0000, 1'b0, 11'd0, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			offer_price(rows[k].price, rows[k].known, rows[k].span, rows[k].saturated);
		end

		// random runs: noise, narrow bands with many equal prices, ramps, extremes
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(4);
			run = $urandom_range(5, 60);
			level = $urandom;
			step = $urandom_range(3);
			for (i = 0; i < run; i++) begin
				case (kind)
					0: level = $urandom;
					1: level = $signed($urandom_range(15)) - 8;
					2: level = level + step;
					3: level = level - step;
					default: begin
						case ($urandom_range(4))
							0: level = 32'h7fff_ffff;
							1: level = 32'h8000_0000;
							2: level = 32'hffff_ffff;
							3: level = 32'h0000_0000;
							default: level = 32'h7fff_fffe;
						endcase
					end
				endcase
				offer_price(level, 1'b0, '0, 1'b0);
				random_sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (span_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
